// ----- design/chm_pkg.sv -----
// ----------------------------------------------------------------------------
// Chained hash map package
// Shared sizes, codes, types and the value mask helper.
// ----------------------------------------------------------------------------
package chm_pkg;
    localparam int POOL_ENTRIES      = 1024;
    localparam int DEFAULT_BIN_LEVEL = 4;
    localparam int MAX_BIN_LEVEL     = 10;
    localparam int LOAD_DENSITY      = 5;
    localparam int IDX_W   = $clog2(POOL_ENTRIES + 1);
    localparam int ADR_W   = $clog2(POOL_ENTRIES);
    localparam int LVL_W   = $clog2(MAX_BIN_LEVEL + 1);
    localparam int MAX_BINS = 1 << MAX_BIN_LEVEL;
    localparam int BIN_W   = (MAX_BIN_LEVEL < 1) ? 1 : MAX_BIN_LEVEL;
    localparam logic [IDX_W-1:0] NIL = IDX_W'(POOL_ENTRIES);
    localparam logic [LVL_W-1:0] INIT_LEVEL = LVL_W'((DEFAULT_BIN_LEVEL > MAX_BIN_LEVEL)
                                              ? MAX_BIN_LEVEL : DEFAULT_BIN_LEVEL);

    // request action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_INS_CHK, S_GR_HEAD, S_GR_RD, S_GR_LINK, S_GR_WLO, S_GR_WHI,
        S_INS_HEAD, S_INS_WR, S_LK_HEAD, S_LK_FIRST, S_LK_CMP, S_OUT
    } t_state;

    typedef struct packed {
        logic        found;
        logic [63:0] found_value;
        logic        pool_full;
    } t_result;

    function automatic logic [63:0] value_mask(input logic [3:0] nb);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (nb > 4'(i)) m[i*8 +: 8] = 8'hFF;
        end
        return m;
    endfunction
endpackage

// ----- design/chm_if.sv -----
// ----------------------------------------------------------------------------
// Stream channels
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface chm_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] key_node;
    logic [63:0] value;
    modport source (output valid, action, key_node, value, input ready);
    modport sink   (input valid, action, key_node, value, output ready);
endinterface

interface chm_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [63:0] found_value;
    logic        pool_full;
    modport source (output valid, found, found_value, pool_full, input ready);
    modport sink   (input valid, found, found_value, pool_full, output ready);
endinterface

// ----- design/chained_hash_map_with_growth_unit.sv -----
// An insert checks pool and growth, reads the bin head, then writes the
//   entry; a full pool skips to the result. A lookup reads the bin head,
//   then compares chain entries in turn. Growth splits each old bin into
//   a low and a high new bin. One transaction in flight; the next is taken
//   in the cycle after the result transaction. Reset: synchronous; count 0,
//   default level; a pass clears default-level bin heads before requests open.
// ----------------------------------------------------------------------------
// Chained hash map with growth
// One bin head RAM and one entry RAM (key, link, value), walked by an FSM.
// ----------------------------------------------------------------------------
module chained_hash_map_with_growth_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    chm_req_if.sink    req,
    chm_rsp_if.source  rsp
);
    import chm_pkg::*;

    localparam int ENT_W = 32 + IDX_W + 64;

    t_state           r_state, n_state;
    logic [3:0]       r_vbytes;
    logic [IDX_W-1:0] r_count, n_count;
    logic [LVL_W-1:0] r_level, n_level;
    logic [BIN_W-1:0] r_b, n_b;
    logic [IDX_W-1:0] r_p, n_p;
    logic [IDX_W-1:0] r_flo, n_flo;       // new low-half bin head during relink
    logic [IDX_W-1:0] r_fhi, n_fhi;       // new high-half bin head during relink
    logic [31:0]      r_key;
    logic [63:0]      r_val;
    t_result          r_res, n_res;

    // bin head RAM
    logic             h_we;
    logic [BIN_W-1:0] h_waddr, h_raddr;
    logic [IDX_W-1:0] h_wdata, h_rdata;
    // entry RAM: key, link, value
    logic             e_we;
    logic [ADR_W-1:0] e_waddr, e_raddr;
    logic [31:0]      e_wkey, e_rkey;
    logic [IDX_W-1:0] e_wlink, e_rlink;
    logic [63:0]      e_wval, e_rval;

    chm_ram #(.DW(IDX_W), .AW(BIN_W)) u_head (.i_clk, .i_we(h_we), .i_waddr(h_waddr),
        .i_wdata(h_wdata), .i_raddr(h_raddr), .o_rdata(h_rdata));
    chm_ram #(.DW(ENT_W), .AW(ADR_W)) u_ent (.i_clk, .i_we(e_we), .i_waddr(e_waddr),
        .i_wdata({e_wkey, e_wlink, e_wval}), .i_raddr(e_raddr),
        .o_rdata({e_rkey, e_rlink, e_rval}));

    logic [BIN_W-1:0] lvl_mask, hi_bin, kbin;
    logic [31:0]      limit;
    logic             grow;
    logic             key_hi;
    always_comb begin
        lvl_mask = BIN_W'((32'd1 << r_level) - 32'd1);
        hi_bin   = BIN_W'(32'd1 << r_level);
        kbin     = r_key[BIN_W-1:0] & lvl_mask;
        limit    = 32'(LOAD_DENSITY) << r_level;
        grow     = ((32'(r_count) + 32'd1) >= limit) && (r_level < LVL_W'(MAX_BIN_LEVEL));
        key_hi   = e_rkey[r_level];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_level = r_level;
        n_b     = r_b;
        n_p     = r_p;
        n_flo   = r_flo;
        n_fhi   = r_fhi;
        n_res   = r_res;
        h_we    = 1'b0;
        h_waddr = r_b;
        h_wdata = NIL;
        h_raddr = kbin;
        e_we    = 1'b0;
        e_waddr = r_count[ADR_W-1:0];
        e_wkey  = r_key;
        e_wlink = h_rdata;
        e_wval  = r_val & value_mask(r_vbytes);
        req.ready = 1'b0;
        rsp.valid = 1'b0;
        unique case (r_state)
            S_CLR: begin
                // empty the bin heads of the default level after reset
                h_we    = 1'b1;
                h_waddr = r_b;
                h_wdata = NIL;
                n_b     = r_b + 1'b1;
                if (r_b == lvl_mask) begin
                    n_b     = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                req.ready = 1'b1;
                if (req.valid) n_state = (req.action == ACT_LOOKUP) ? S_LK_HEAD : S_INS_CHK;
            end
            S_INS_CHK: begin
                if (r_count == NIL) begin
                    n_res           = '0;
                    n_res.pool_full = 1'b1;
                    n_state         = S_OUT;
                end else if (grow) begin
                    n_b     = '0;
                    n_state = S_GR_HEAD;
                end else begin
                    n_state = S_INS_HEAD;
                end
            end
            S_GR_HEAD: begin
                // read the head of old bin r_b, start both new heads empty
                h_raddr = r_b;
                n_flo   = NIL;
                n_fhi   = NIL;
                n_state = S_GR_RD;
            end
            S_GR_RD: begin
                n_p     = h_rdata;
                n_state = (h_rdata == NIL) ? S_GR_WLO : S_GR_LINK;
            end
            S_GR_LINK: begin
                // push the entry onto the front of its new bin
                e_we    = 1'b1;
                e_waddr = r_p[ADR_W-1:0];
                e_wkey  = e_rkey;
                e_wval  = e_rval;
                if (key_hi) begin
                    e_wlink = r_fhi;
                    n_fhi   = r_p;
                end else begin
                    e_wlink = r_flo;
                    n_flo   = r_p;
                end
                n_p = e_rlink;
                if (e_rlink == NIL) n_state = S_GR_WLO;
            end
            S_GR_WLO: begin
                h_we    = 1'b1;
                h_waddr = r_b;
                h_wdata = r_flo;
                n_state = S_GR_WHI;
            end
            S_GR_WHI: begin
                h_we    = 1'b1;
                h_waddr = r_b | hi_bin;
                h_wdata = r_fhi;
                if (r_b == lvl_mask) begin
                    n_b     = '0;
                    n_level = r_level + 1'b1;
                    n_state = S_INS_HEAD;
                end else begin
                    n_b     = r_b + 1'b1;
                    n_state = S_GR_HEAD;
                end
            end
            S_INS_HEAD: begin
                h_raddr = kbin;
                n_state = S_INS_WR;
            end
            S_INS_WR: begin
                // store the new entry and make it the head of its bin
                e_we    = 1'b1;
                e_waddr = r_count[ADR_W-1:0];
                e_wkey  = r_key;
                e_wlink = h_rdata;
                h_we    = 1'b1;
                h_waddr = kbin;
                h_wdata = r_count;
                n_count = r_count + 1'b1;
                n_res   = '0;
                n_state = S_OUT;
            end
            S_LK_HEAD: begin
                h_raddr = kbin;
                n_state = S_LK_FIRST;
            end
            S_LK_FIRST: begin
                n_p     = h_rdata;
                n_res   = '0;
                n_state = (h_rdata == NIL) ? S_OUT : S_LK_CMP;
            end
            S_LK_CMP: begin
                if (e_rkey == r_key) begin
                    n_res.found       = 1'b1;
                    n_res.found_value = e_rval;
                    n_state           = S_OUT;
                end else begin
                    n_p = e_rlink;
                    if (e_rlink == NIL) n_state = S_OUT;
                end
            end
            S_OUT: begin
                rsp.valid = 1'b1;
                if (rsp.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        // read the entry that the walk moves to next
        e_raddr = n_p[ADR_W-1:0];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_count  <= '0;
            r_level  <= INIT_LEVEL;
            r_b      <= '0;
            r_vbytes <= 4'd8;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_level <= n_level;
            r_b     <= n_b;
            if (i_cfg_we) r_vbytes <= i_cfg_wdata;
        end
    end

    // datapath registers; capture the request transaction
    always_ff @(posedge i_clk) begin
        r_p   <= n_p;
        r_flo <= n_flo;
        r_fhi <= n_fhi;
        r_res <= n_res;
        if (req.valid && req.ready) begin
            r_key <= req.key_node;
            r_val <= req.value;
        end
    end

    assign rsp.found       = r_res.found;
    assign rsp.found_value = r_res.found_value;
    assign rsp.pool_full   = r_res.pool_full;

    // checks
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NIL) else $error("count overflow");
    a_lvl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LVL_W'(MAX_BIN_LEVEL)) else $error("level overflow");
    a_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.valid && rsp.pool_full |-> !rsp.found && rsp.found_value == '0)
        else $error("bad result");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.valid |-> !req.ready) else $error("request taken while result waits");
endmodule

// ----- design/chm_ram.sv -----
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module chm_ram #(
    parameter int DW = 8,
    parameter int AW = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] mem [1<<AW];
    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
        o_rdata <= mem[i_raddr];
    end
endmodule

// ----- tb/chained_hash_map_with_growth_unit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash map result checker
// Watches the request and result channels, keeps its own copy of the chained
// map (pool, bin chains, growth relinking) and compares every result.
// ----------------------------------------------------------------------------
module chained_hash_map_with_growth_unit_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    input  logic       i_req_valid,
    input  logic       i_req_ready,
    input  logic       i_req_action,
    input  logic [31:0] i_req_key,
    input  logic [63:0] i_req_value,
    input  logic       i_rsp_valid,
    input  logic       i_rsp_ready,
    input  logic       i_rsp_found,
    input  logic [63:0] i_rsp_found_value,
    input  logic       i_rsp_pool_full,
    output int         o_fail_count,
    output int         o_pending
);
    import chm_pkg::*;

    int      heads [MAX_BINS];
    int      keys_mem [POOL_ENTRIES];
    logic [63:0] vals_mem [POOL_ENTRIES];
    int      links [POOL_ENTRIES];
    int      stored;
    int      level;
    logic [3:0] byte_count;
    t_result expected_results [$];
    int      mismatches;

    function automatic int bin_index(input logic [31:0] k);
        return int'(k & ((32'd1 << level) - 1));
    endfunction

    function automatic logic [63:0] byte_mask();
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (byte_count > i) m[i*8 +: 8] = 8'hFF;
        end
        return m;
    endfunction

    // Rebuild chains at one level higher, old bins upward, head to tail
    function automatic void grow_map();
        int fresh [MAX_BINS];
        int old_bins;
        int p;
        int nxt;
        int nb;
        old_bins = 1 << level;
        level++;
        for (int i = 0; i < MAX_BINS; i++) fresh[i] = POOL_ENTRIES;
        for (int b = 0; b < old_bins; b++) begin
            p = heads[b];
            while (p < POOL_ENTRIES) begin
                nxt = links[p];
                nb = bin_index(keys_mem[p]);
                links[p] = fresh[nb];
                fresh[nb] = p;
                p = nxt;
            end
        end
        heads = fresh;
    endfunction

    function automatic t_result map_access(input logic act, input logic [31:0] k,
                                           input logic [63:0] v);
        t_result r;
        int p;
        int slot;
        r = '0;
        if (act == ACT_INSERT) begin
            if (stored >= POOL_ENTRIES) begin
                r.pool_full = 1'b1;
                return r;
            end
            stored++;
            if (stored >= (1 << level) * LOAD_DENSITY && level < MAX_BIN_LEVEL) grow_map();
            slot = stored - 1;
            keys_mem[slot] = k;
            vals_mem[slot] = v & byte_mask();
            links[slot] = heads[bin_index(k)];
            heads[bin_index(k)] = slot;
        end else begin
            p = heads[bin_index(k)];
            while (p < POOL_ENTRIES) begin
                if (keys_mem[p] == k) begin
                    r.found = 1'b1;
                    r.found_value = vals_mem[p];
                    break;
                end
                p = links[p];
            end
        end
        return r;
    endfunction

    assign o_fail_count = mismatches;
    assign o_pending = expected_results.size();

    // Track state, predict on request transactions, compare on result ones
    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_BINS; i++) heads[i] = POOL_ENTRIES;
            stored = 0;
            level = INIT_LEVEL;
            byte_count = 4'd8;
            expected_results.delete();
            mismatches = 0;
        end else begin
            if (i_cfg_we) byte_count = (i_cfg_wdata > 8) ? 4'd8 : i_cfg_wdata;
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("ERROR: result with nothing expected");
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.found !== i_rsp_found || exp_r.found_value !== i_rsp_found_value
                        || exp_r.pool_full !== i_rsp_pool_full) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: exp found=%0b val=%h full=%0b got %0b %h %0b",
                                     exp_r.found, exp_r.found_value, exp_r.pool_full,
                                     i_rsp_found, i_rsp_found_value, i_rsp_pool_full);
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                expected_results.push_back(map_access(i_req_action, i_req_key, i_req_value));
        end
    end
endmodule

// ----- tb/chained_hash_map_with_growth_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash map unit testbench
// Drives inserts and lookups through growth, across value widths, with
// random idling and a long result stall; a checker compares.
// ----------------------------------------------------------------------------
module chained_hash_map_with_growth_unit_test;
    import chm_pkg::*;

    localparam int   IDLE_LIMIT = 20000;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [3:0] cfg_wdata;
    int         fail_count;
    int         pending;
    int         quiet_cycles;
    bit         calm_mode;
    bit         hold_results;
    logic [31:0] used_keys [$];

    chm_req_if req ();
    chm_rsp_if rsp ();

    chained_hash_map_with_growth_unit dut (
        .i_clk, .i_rst_n, .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .req(req.sink), .rsp(rsp.source)
    );

    chained_hash_map_with_growth_unit_checker checker_inst (
        .i_clk, .i_rst_n, .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_req_valid(req.valid), .i_req_ready(req.ready), .i_req_action(req.action),
        .i_req_key(req.key_node), .i_req_value(req.value),
        .i_rsp_valid(rsp.valid), .i_rsp_ready(rsp.ready), .i_rsp_found(rsp.found),
        .i_rsp_found_value(rsp.found_value), .i_rsp_pool_full(rsp.pool_full),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Send one transaction, idling now and then beforehand; valid stays up
    // after acceptance until the next call or the caller drops it
    task automatic send_item(input logic act, input logic [31:0] k, input logic [63:0] v);
        while (!calm_mode && $urandom_range(99) < 13) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid <= 1'b1;
        req.action <= act;
        req.key_node <= k;
        req.value <= v;
        if (act == ACT_INSERT) used_keys.push_back(k);
        do @(posedge i_clk); while (!req.ready);
    endtask

    task automatic write_width(input logic [3:0] nb);
        req.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= nb;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_key();
        if (used_keys.size() != 0 && $urandom_range(99) < 60)
            return used_keys[$urandom_range(used_keys.size() - 1)];
        return ($urandom_range(1)) ? $urandom : 32'($urandom_range(300));
    endfunction

    function automatic logic [63:0] rand_value();
        return {$urandom, $urandom};
    endfunction

    task automatic random_items(input int count, input int insert_pct);
        for (int i = 0; i < count; i++) begin
            calm_mode = (i % 200) >= 150;
            send_item(($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_LOOKUP,
                      pick_key(), rand_value());
        end
        calm_mode = 1'b0;
    endtask

    // Result side: random idling, one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) rsp.ready <= 1'b0;
        else rsp.ready <= !hold_results && (calm_mode || $urandom_range(99) >= 13);
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.action = ACT_INSERT;
        req.key_node = '0;
        req.value = '0;
        calm_mode = 1'b0;
        hold_results = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: lookup on empty, extremes, duplicates, same-bin chains
        send_item(ACT_LOOKUP, 32'hFFFF_FFFF, '0);
        send_item(ACT_INSERT, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(ACT_INSERT, 32'hFFFF_FFFF, 64'h0);
        send_item(ACT_INSERT, 32'h10, 64'h1111);
        send_item(ACT_INSERT, 32'h10, 64'h2222);
        send_item(ACT_INSERT, 32'h20, 64'hAAAA_5555_AAAA_5555);
        send_item(ACT_LOOKUP, 32'h10, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(ACT_LOOKUP, 32'h0, '0);
        send_item(ACT_LOOKUP, 32'hFFFF_FFFF, '0);
        send_item(ACT_LOOKUP, 32'h30, '0);

        // Value width 0, 3, 15 on stored entries
        write_width(4'd0);
        send_item(ACT_INSERT, 32'h5, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(ACT_LOOKUP, 32'h5, '0);
        write_width(4'd3);
        send_item(ACT_INSERT, 32'h6, 64'h5555_AAAA_5555_AAAA);
        send_item(ACT_LOOKUP, 32'h6, '0);
        write_width(4'd15);
        send_item(ACT_INSERT, 32'h7, 64'hDEAD_BEEF_CAFE_F00D);
        send_item(ACT_LOOKUP, 32'h6, '0);
        send_item(ACT_LOOKUP, 32'h7, '0);

        // Long result stall while requests keep coming
        fork
            begin
                hold_results = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_results = 1'b0;
            end
            random_items(6, 50);
        join

        // Random phases across widths; inserts drive the map through growth
        random_items(250, 60);
        write_width(4'd1);
        random_items(250, 60);
        write_width(4'd8);
        random_items(300, 70);
        write_width(4'd7);
        // Last phase, mostly inserts
        random_items(230, 75);

        req.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
